>>> design/rbm_pkg.sv
// Package for the RBM layer sampler: beat types, command codes, constants,
// sigmoid table. No dependencies.
package rbm_pkg;

    localparam int MAX_VISIBLE = 64;
    localparam int MAX_HIDDEN  = 64;
    localparam int VIS_W       = 6;
    localparam int HID_W       = 6;
    localparam int ACC_W       = 24;

    localparam logic [2:0] CMD_WEIGHT  = 3'd0;
    localparam logic [2:0] CMD_VBIAS   = 3'd1;
    localparam logic [2:0] CMD_HBIAS   = 3'd2;
    localparam logic [2:0] CMD_VBIT    = 3'd3;
    localparam logic [2:0] CMD_HBIT    = 3'd4;
    localparam logic [2:0] CMD_SAMP_H  = 3'd5;
    localparam logic [2:0] CMD_SAMP_V  = 3'd6;

    localparam logic [1:0] REG_NUM_VIS = 2'd0;
    localparam logic [1:0] REG_NUM_HID = 2'd1;
    localparam logic [1:0] REG_SEED    = 2'd2;

    localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] value;
        logic               unit_bit;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  unit_index;
        logic [15:0] probability;
        logic        sampled_bit;
        logic        layer;
        logic        last;
    } t_out_beat;

    function automatic logic [15:0] sig_tab(input logic [3:0] k);
        case (k)
            4'd0:    sig_tab = 16'd32768;
            4'd1:    sig_tab = 16'd47911;
            4'd2:    sig_tab = 16'd57724;
            4'd3:    sig_tab = 16'd62428;
            4'd4:    sig_tab = 16'd64357;
            4'd5:    sig_tab = 16'd65097;
            4'd6:    sig_tab = 16'd65374;
            4'd7:    sig_tab = 16'd65476;
            default: sig_tab = 16'd65514;
        endcase
    endfunction

endpackage

>>> design/rbm_layer_sampler.sv
// Top level of the RBM layer sampler: stores, accumulate sequencer, LFSR.
// Depends on rbm_pkg and rbm_sigmoid.
//
// A write command (weight, bias or unit bit) passes through the write state:
// busy rises for one cycle after start. A layer sample takes, per unit, a
// bias read, one weight read per unit of the other layer (from the one read
// port of the weight memory, gated by that layer's bit), the drain state that
// folds the last read into the sum, the sigmoid stage, sixteen LFSR shifts
// (one shift per cycle) and a state to emit the beat. The weight memory port
// and the serial draw set the pace. One result beat per unit leaves on
// o_valid for exactly one cycle in ascending unit order, with last on the
// final unit; the receiver cannot stall, so take each beat as it comes.
// Configuration writes go through at any time the block is idle; a seed write
// also reloads the LFSR (zero loads 1).
module rbm_layer_sampler
    import rbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_beat    i_in,
    output logic        o_valid,
    output t_out_beat   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_BIAS, S_ACC, S_DRAIN, S_SIG, S_DRAW, S_EMIT
    } t_state;

    t_state r_state;

    // Stores
    logic signed [15:0] r_wmem [MAX_VISIBLE*MAX_HIDDEN];
    logic signed [15:0] r_vbias [MAX_VISIBLE];
    logic signed [15:0] r_hbias [MAX_HIDDEN];
    logic [MAX_VISIBLE-1:0] r_vbits;
    logic [MAX_HIDDEN-1:0]  r_hbits;

    logic [6:0]  r_num_vis, r_num_hid;
    logic [31:0] r_lfsr;

    t_in_beat    r_cmd;
    logic        r_is_vis;
    logic [6:0]  r_unit, r_n_units;
    logic [6:0]  r_other, r_n_other;
    logic [1:0]  r_drain;
    logic [3:0]  r_step;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0] r_wrd, r_brd;
    logic        r_wrd_en;
    logic [15:0] r_prob;
    logic [15:0] prob;

    logic [6:0]  nv, nh;
    logic [11:0] waddr;
    logic        gate;
    logic [31:0] lfsr_next;
    logic        samp;

    rbm_sigmoid u_sig (.i_clk(i_clk), .i_sum(r_acc), .o_prob(prob));

    always_comb begin
        nv = (r_num_vis == 7'd0) ? 7'd1 : (r_num_vis > 7'(MAX_VISIBLE)) ?
             7'(MAX_VISIBLE) : r_num_vis;
        nh = (r_num_hid == 7'd0) ? 7'd1 : (r_num_hid > 7'(MAX_HIDDEN)) ?
             7'(MAX_HIDDEN) : r_num_hid;
        // visible layer: row = unit; hidden layer: row = other
        waddr = r_is_vis ? {r_unit[5:0], r_other[5:0]} : {r_other[5:0], r_unit[5:0]};
        gate  = r_is_vis ? r_hbits[r_other[5:0]] : r_vbits[r_other[5:0]];
        lfsr_next = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
        samp  = r_lfsr[15:0] < r_prob;
        o_busy = (r_state != S_IDLE);
    end

    // Weight memory, one write port and one read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_cmd.cmd == CMD_WEIGHT)
            r_wmem[{r_cmd.row, r_cmd.col}] <= r_cmd.value;
        r_wrd <= r_wmem[waddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_cmd.cmd == CMD_VBIAS) r_vbias[r_cmd.row] <= r_cmd.value;
        if (r_state == S_WRITE && r_cmd.cmd == CMD_HBIAS) r_hbias[r_cmd.col] <= r_cmd.value;
        r_brd <= r_is_vis ? r_vbias[r_unit[5:0]] : r_hbias[r_unit[5:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vbits   <= '0;
            r_hbits   <= '0;
            r_num_vis <= 7'd64;
            r_num_hid <= 7'd64;
            r_lfsr    <= 32'd1;
            o_valid   <= 1'b0;
            r_wrd_en  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NUM_VIS: r_num_vis <= i_cfg_data[6:0];
                    REG_NUM_HID: r_num_hid <= i_cfg_data[6:0];
                    REG_SEED:    r_lfsr <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd    <= i_in;
                        r_is_vis <= (i_in.cmd == CMD_SAMP_V);
                        r_unit   <= 7'd0;
                        if (i_in.cmd == CMD_SAMP_V) begin
                            r_n_units <= nv; r_n_other <= nh;
                            r_state <= S_BIAS;
                        end else if (i_in.cmd == CMD_SAMP_H) begin
                            r_n_units <= nh; r_n_other <= nv;
                            r_state <= S_BIAS;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_cmd.cmd == CMD_VBIT) r_vbits[r_cmd.row] <= r_cmd.unit_bit;
                    if (r_cmd.cmd == CMD_HBIT) r_hbits[r_cmd.col] <= r_cmd.unit_bit;
                    r_state <= S_IDLE;
                end
                S_BIAS: begin
                    // bias read issued this cycle; the first weight read follows in S_ACC
                    r_other  <= 7'd0;
                    r_wrd_en <= 1'b0;
                    r_acc    <= '0;
                    r_state  <= S_ACC;
                end
                S_ACC: begin
                    // accumulate the previous read, issue the next
                    if (r_other == 7'd0) r_acc <= ACC_W'(r_brd);
                    else if (r_wrd_en)   r_acc <= r_acc + ACC_W'(r_wrd);
                    r_wrd_en <= gate;
                    r_other  <= r_other + 7'd1;
                    if (r_other + 7'd1 == r_n_other) begin
                        r_drain <= 2'd0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_n_other == 7'd1 && r_drain == 2'd0)
                        r_acc <= ACC_W'(r_brd) + (r_wrd_en ? ACC_W'(r_wrd) : '0);
                    else if (r_drain == 2'd0 && r_wrd_en)
                        r_acc <= r_acc + ACC_W'(r_wrd);
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd1) r_state <= S_SIG;
                end
                S_SIG: begin
                    r_prob  <= prob;
                    r_step  <= 4'd0;
                    r_state <= S_DRAW;
                end
                S_DRAW: begin
                    // one LFSR shift per cycle
                    r_lfsr <= lfsr_next;
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    o_out.unit_index  <= r_unit[5:0];
                    o_out.probability <= r_prob;
                    o_out.sampled_bit <= samp;
                    o_out.layer       <= r_is_vis;
                    o_out.last        <= (r_unit + 7'd1 == r_n_units);
                    if (r_is_vis) r_vbits[r_unit[5:0]] <= samp;
                    else          r_hbits[r_unit[5:0]] <= samp;
                    r_unit <= r_unit + 7'd1;
                    r_state <= (r_unit + 7'd1 == r_n_units) ? S_IDLE : S_BIAS;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/rbm_sigmoid.sv
// Registered sigmoid: saturate a Q4.12 sum and interpolate the table.
// Multiply into a register, then round and fold sign. Depends on rbm_pkg.
module rbm_sigmoid
    import rbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [ACC_W-1:0] i_sum,
    output logic [15:0]             o_prob
);
    logic signed [15:0] sat;
    logic [16:0]        mag;
    logic [3:0]         k;
    logic [11:0]        f;
    logic [15:0]        base;
    logic [15:0]        delta;
    logic [27:0]        r_prod;
    logic [15:0]        r_base;
    logic               r_neg;
    logic [16:0]        p;

    always_comb begin
        if (i_sum > ACC_W'(32767))       sat = 16'sd32767;
        else if (i_sum < -ACC_W'(32768)) sat = -16'sd32768;
        else                             sat = i_sum[15:0];
        mag   = sat[15] ? 17'(-{sat[15], sat}) : 17'({1'b0, sat});
        k     = mag[15:12];
        f     = mag[11:0];
        base  = sig_tab(k);
        delta = (k < 4'd8) ? sig_tab(k + 4'd1) - base : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 28'(delta) * 28'(f);
        r_base <= base;
        r_neg  <= sat[15];
    end

    always_comb begin
        p = 17'(r_base) + 17'((r_prod + 28'd2048) >> 12);
        if (r_neg) p = 17'h10000 - p;
        o_prob = (p > 17'd65535) ? 16'hFFFF : p[15:0];
    end
endmodule

>>> tb/sv/rbm_layer_sampler_tb.sv
// Self-checking testbench for rbm_layer_sampler: loads the stores, then runs
// directed and random command beats over several unit-count and seed settings.
// Depends on rbm_pkg and the rbm_layer_sampler RTL.
module rbm_layer_sampler_tb;
    import rbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_IDLE = 3'd7;  // unused code, no effect
    localparam logic [31:0] SIGMOID_KNOTS [9] = '{32768, 47911, 57724, 62428, 64357,
                                                  65097, 65374, 65476, 65514};
    // Units 0..ACTIVE-1 of each layer get weights and biases; only they are sampled.
    localparam int ACTIVE = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in_beat    i_in = '0;
    logic        o_valid;
    t_out_beat   o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_NUM_VIS;
    logic [31:0] i_cfg_data = '0;

    rbm_layer_sampler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the sampler: stores, unit bits, LFSR and registers.
    int          w_mem [MAX_VISIBLE*MAX_HIDDEN];
    int          vbias_mem [MAX_VISIBLE];
    int          hbias_mem [MAX_HIDDEN];
    logic [63:0] vis_state;
    logic [63:0] hid_state;
    logic [31:0] lfsr;
    logic [6:0]  nvis_reg;
    logic [6:0]  nhid_reg;

    t_in_beat  cmd_q [$];       // command beats waiting to be sent
    t_out_beat unit_results_q [$];  // predicted result beats, oldest first
    bit        no_gaps;
    int        gap_left;
    int        errors;
    int        beats_sent;
    int        beats_checked;

    function automatic int clamp_units(logic [6:0] v);
        if (v == 0) return 1;
        return (v > 64) ? 64 : int'(v);
    endfunction

    // Saturate to Q4.12, interpolate the sigmoid knots, mirror for negatives.
    function automatic logic [15:0] firing_prob(int s);
        int a, k, f, p;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        a = (s < 0) ? -s : s;
        k = a >> 12;
        f = a & 4095;
        p = SIGMOID_KNOTS[k];
        if (f != 0 && k < 8)
            p = p + (((SIGMOID_KNOTS[k+1] - SIGMOID_KNOTS[k]) * f + 2048) >>> 12);
        if (s < 0) p = 65536 - p;
        if (p > 65535) p = 65535;
        return p[15:0];
    endfunction

    // Advance the Galois LFSR by 16 shifts and return the low half.
    function automatic logic [15:0] next_draw();
        for (int n = 0; n < 16; n++) begin
            if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
            else lfsr = lfsr >> 1;
        end
        return lfsr[15:0];
    endfunction

    // Apply one accepted command to the shadow state, queue its result beats.
    task automatic predict_layer(t_in_beat c);
        int nv, nh, n, s;
        t_out_beat r;
        logic [15:0] p, d;
        bit vis;
        nv = clamp_units(nvis_reg);
        nh = clamp_units(nhid_reg);
        case (c.cmd)
            CMD_WEIGHT: w_mem[c.row*MAX_HIDDEN + c.col] = int'(c.value);
            CMD_VBIAS:  vbias_mem[c.row] = int'(c.value);
            CMD_HBIAS:  hbias_mem[c.col] = int'(c.value);
            CMD_VBIT:   vis_state[c.row] = c.unit_bit;
            CMD_HBIT:   hid_state[c.col] = c.unit_bit;
            CMD_SAMP_H, CMD_SAMP_V: begin
                vis = (c.cmd == CMD_SAMP_V);
                n = vis ? nv : nh;
                for (int u = 0; u < n; u++) begin
                    if (vis) begin
                        s = vbias_mem[u];
                        for (int o = 0; o < nh; o++)
                            if (hid_state[o]) s += w_mem[u*MAX_HIDDEN + o];
                    end else begin
                        s = hbias_mem[u];
                        for (int o = 0; o < nv; o++)
                            if (vis_state[o]) s += w_mem[o*MAX_HIDDEN + u];
                    end
                    p = firing_prob(s);
                    d = next_draw();
                    r.unit_index  = u[5:0];
                    r.probability = p;
                    r.sampled_bit = (d < p);
                    r.layer       = vis;
                    r.last        = (u == n - 1);
                    if (vis) vis_state[u] = r.sampled_bit;
                    else hid_state[u] = r.sampled_bit;
                    unit_results_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Driver: hold start until the beat is taken, then idle for the drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            gap_left <= 0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                predict_layer(i_in);
                beats_sent++;
            end
            if (gap_left != 0) begin
                i_start  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_q.size() != 0) begin
                i_in     <= cmd_q.pop_front();
                i_start  <= 1'b1;
                gap_left <= no_gaps ? 0 : $urandom_range(0, 17);
            end else begin
                i_start  <= 1'b0;
            end
        end
    end

    // Monitor: every strobed beat must match the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid) begin
            if (unit_results_q.size() == 0) begin
                errors++;
                $display("[%0t] UNEXPECTED result beat, unit %0d", $realtime, o_out.unit_index);
            end else begin
                want = unit_results_q.pop_front();
                beats_checked++;
                if (o_out.unit_index !== want.unit_index)
                    report_mismatch("unit_index", o_out.unit_index, want.unit_index);
                if (o_out.probability !== want.probability)
                    report_mismatch("probability", o_out.probability, want.probability);
                if (o_out.sampled_bit !== want.sampled_bit)
                    report_mismatch("sampled_bit", o_out.sampled_bit, want.sampled_bit);
                if (o_out.layer !== want.layer)
                    report_mismatch("layer", o_out.layer, want.layer);
                if (o_out.last !== want.last)
                    report_mismatch("last", o_out.last, want.last);
            end
        end
    end

    function automatic t_in_beat make_beat(logic [2:0] cmd, int row, int col,
                                           int value, bit ubit);
        t_in_beat b;
        b.cmd = cmd;
        b.row = row[5:0];
        b.col = col[5:0];
        b.value = value[15:0];
        b.unit_bit = ubit;
        return b;
    endfunction

    // Random beat: mostly writes, a quarter layer samples, some unused codes.
    // A layer whose count reaches past the loaded units is not sampled, and
    // unit bits are only set inside the loaded units.
    function automatic t_in_beat random_beat(bit allow_h, bit allow_v);
        int sel, v, row, col;
        logic [2:0] cmd;
        sel = $urandom_range(0, 99);
        if (sel < 70) cmd = 3'($urandom_range(0, 4));
        else if (sel < 95) cmd = ($urandom_range(0, 1) != 0) ? CMD_SAMP_H : CMD_SAMP_V;
        else cmd = CMD_IDLE;
        if (cmd == CMD_SAMP_H && !allow_h) cmd = allow_v ? CMD_SAMP_V : CMD_IDLE;
        if (cmd == CMD_SAMP_V && !allow_v) cmd = allow_h ? CMD_SAMP_H : CMD_IDLE;
        row = $urandom;
        col = $urandom;
        if (cmd == CMD_VBIT || cmd == CMD_HBIT) begin
            row = $urandom_range(0, ACTIVE - 1);
            col = $urandom_range(0, ACTIVE - 1);
        end
        v = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 6000) - 3000 : $urandom;
        return make_beat(cmd, row, col, v, $urandom_range(0, 1));
    endfunction

    // Register write at a clock edge; the block is idle here.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_NUM_VIS: nvis_reg = data[6:0];
            REG_NUM_HID: nhid_reg = data[6:0];
            REG_SEED:    lfsr = (data == 0) ? 32'd1 : data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold off until every queued beat is taken and every result has come.
    task automatic drain();
        wait (cmd_q.size() == 0 && !i_start && unit_results_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [6:0]  nv_set [7];
        logic [6:0]  nh_set [7];
        logic [31:0] seed_set [7];
        bit          allow_h;
        bit          allow_v;
        vis_state = '0;
        hid_state = '0;
        lfsr      = 32'd1;
        nvis_reg  = 7'd64;
        nhid_reg  = 7'd64;
        no_gaps   = 1'b0;
        errors    = 0;
        beats_sent = 0;
        beats_checked = 0;
        nv_set   = '{7'd1, 7'd127, 7'd0, 7'd2, 7'd5, 7'd8, 7'd3};
        nh_set   = '{7'd1, 7'd8, 7'd0, 7'd5, 7'd2, 7'd7, 7'd64};
        seed_set = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, $urandom, $urandom, 32'h8000_0000};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load the weights and biases of the active units; nothing else is read.
        no_gaps = 1'b1;
        for (int r = 0; r < ACTIVE; r++)
            for (int c = 0; c < ACTIVE; c++)
                cmd_q.push_back(make_beat(CMD_WEIGHT, r, c,
                                          $urandom_range(0, 3072) - 1536, 0));
        for (int u = 0; u < ACTIVE; u++) begin
            cmd_q.push_back(make_beat(CMD_VBIAS, u, $urandom, $urandom_range(0, 8000) - 4000, 0));
            cmd_q.push_back(make_beat(CMD_HBIAS, $urandom, u, $urandom_range(0, 8000) - 4000, 0));
        end
        drain();
        write_reg(REG_NUM_VIS, 32'(ACTIVE));
        write_reg(REG_NUM_HID, 32'(ACTIVE));

        // Directed: extremes of value, both bit values, unused code, both layers.
        no_gaps = 1'b0;
        cmd_q.push_back(make_beat(CMD_WEIGHT, 0, 0, 32767, 0));
        cmd_q.push_back(make_beat(CMD_WEIGHT, 7, 7, -32768, 1));
        cmd_q.push_back(make_beat(CMD_WEIGHT, 63, 63, -1, 0));
        cmd_q.push_back(make_beat(CMD_VBIAS, 7, 0, 32767, 0));
        cmd_q.push_back(make_beat(CMD_HBIAS, 0, 7, -32768, 0));
        cmd_q.push_back(make_beat(CMD_VBIT, 0, 0, 0, 1));
        cmd_q.push_back(make_beat(CMD_VBIT, 7, 0, 0, 1));
        cmd_q.push_back(make_beat(CMD_VBIT, 63, 0, 0, 0));
        cmd_q.push_back(make_beat(CMD_HBIT, 0, 7, 0, 1));
        cmd_q.push_back(make_beat(CMD_HBIT, 0, 5, 0, 0));
        cmd_q.push_back(make_beat(CMD_IDLE, 63, 63, -1, 1));
        cmd_q.push_back(make_beat(CMD_SAMP_H, 0, 0, 0, 0));
        cmd_q.push_back(make_beat(CMD_SAMP_V, 0, 0, 0, 0));
        cmd_q.push_back(make_beat(CMD_SAMP_H, 63, 63, 0, 1));
        drain();

        // Random phases over unit counts (clamped ones too) and seeds.
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_NUM_VIS, {25'd0, nv_set[ph]});
            write_reg(REG_NUM_HID, {25'd0, nh_set[ph]});
            write_reg(REG_SEED, seed_set[ph]);
            allow_h = (clamp_units(nh_set[ph]) <= ACTIVE);
            allow_v = (clamp_units(nv_set[ph]) <= ACTIVE);
            no_gaps = (ph % 3 == 1);
            for (int i = 0; i < 7; i++)
                cmd_q.push_back(random_beat(allow_h, allow_v));
            drain();
        end

        $display("Sent %0d command beats: store load, corner values, seven random phases",
                 beats_sent);
        $display("with counts 0..127 (clamped), zero seed included; checked %0d result beats",
                 beats_checked);
        if (errors == 0 && unit_results_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout: %0d result beats still expected", unit_results_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
